// ===== hdl/clc_pkg.sv =====
// ----------------------------------------------------------------------------
// clc_pkg - classical letter cipher shared definitions
// Register codes, cipher modes, configuration record and reset values.
// ----------------------------------------------------------------------------
package clc_pkg;

	localparam int DEF_MAX_KEY_LEN = 8;
	localparam int KEY_BITS        = 40;
	localparam int SHIFT_W         = 5;
	localparam int KEY_LETTERS     = KEY_BITS / SHIFT_W;
	localparam int KEY_IDX_W       = 5;   // holds any position or length up to 16
	localparam int CHAR_W          = 8;
	localparam int CFG_DATA_W      = KEY_BITS;

	localparam logic [SHIFT_W-1:0] ALPHA      = 5'd26;
	localparam logic [SHIFT_W-1:0] ALPHA_LAST = 5'd25;
	localparam logic [SHIFT_W-1:0] ROT_AMOUNT = 5'd13;

	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'd65;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'd90;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'd97;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'd122;
	localparam logic [CHAR_W-1:0] CH_DOT     = 8'd46;
	localparam logic [CHAR_W-1:0] CH_SLASH   = 8'd47;

	typedef enum logic [1:0] {
		MODE_ATBASH  = 2'd0,
		MODE_ROT13   = 2'd1,
		MODE_VIG_ENC = 2'd2,
		MODE_VIG_DEC = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_CIPHER_MODE = 2'd0,
		REG_ADD_ATBASH  = 2'd1,
		REG_KEY_LENGTH  = 2'd2,
		REG_KEY_SHIFTS  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		mode_t                cipher_mode;
		logic                 add_atbash;
		logic [3:0]           key_length;
		logic [KEY_BITS-1:0]  key_shifts;
	} cfg_t;

	// "SISOP" packed as five 5-bit shifts, first letter lowest
	localparam cfg_t CFG_RESET = '{
		cipher_mode: MODE_ATBASH,
		add_atbash:  1'b1,
		key_length:  4'd5,
		key_shifts:  40'd16206098
	};

	function automatic logic [SHIFT_W-1:0] mirror(input logic [SHIFT_W-1:0] x);
		mirror = ALPHA_LAST - x;
	endfunction

	// (a + b) mod 26 for a, b below 26
	function automatic logic [SHIFT_W-1:0] add_mod(input logic [SHIFT_W-1:0] a,
		input logic [SHIFT_W-1:0] b);
		logic [SHIFT_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= {1'b0, ALPHA}) begin
			sum = sum - {1'b0, ALPHA};
		end
		add_mod = sum[SHIFT_W-1:0];
	endfunction

endpackage

// ===== hdl/clc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// clc_cfg_regs - configuration register file
// Write-only registers loaded through the enable/index/data port.
// ----------------------------------------------------------------------------
module clc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [clc_pkg::CFG_DATA_W-1:0] cfg_data,
	output clc_pkg::cfg_t                 cfg
);

	clc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= clc_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (clc_pkg::reg_idx_t'(cfg_index))
				clc_pkg::REG_CIPHER_MODE: cfg_q.cipher_mode <= clc_pkg::mode_t'(cfg_data[1:0]);
				clc_pkg::REG_ADD_ATBASH:  cfg_q.add_atbash  <= cfg_data[0];
				clc_pkg::REG_KEY_LENGTH:  cfg_q.key_length  <= cfg_data[3:0];
				clc_pkg::REG_KEY_SHIFTS:  cfg_q.key_shifts  <= cfg_data[clc_pkg::KEY_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/clc_xform.sv =====
// ----------------------------------------------------------------------------
// clc_xform - per-character letter transform
// Key position and dot state, and the combinational letter mapping.
// ----------------------------------------------------------------------------
module clc_xform #(
	parameter int MAX_KEY_LEN = clc_pkg::DEF_MAX_KEY_LEN
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  clc_pkg::cfg_t             cfg,
	input  logic [clc_pkg::CHAR_W-1:0] char_s1,
	input  logic                      start_s1,
	input  logic                      advance,
	output logic [clc_pkg::CHAR_W-1:0] char_res
);

	localparam int KP_W = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
	localparam int IW   = clc_pkg::KEY_IDX_W;
	localparam int SW   = clc_pkg::SHIFT_W;

	logic [KP_W-1:0] key_pos_q, key_pos_d;
	logic            past_dot_q, past_dot_d;

	always_comb begin
		logic [KP_W-1:0]            kp;
		logic                       pd;
		logic [IW-1:0]              len;
		logic [IW-1:0]              pos;
		logic [IW-1:0]              nxt;
		logic [SW-1:0]              shift;
		logic [SW-1:0]              x;
		logic [clc_pkg::CHAR_W-1:0] base;
		logic [clc_pkg::CHAR_W-1:0] diff;
		logic                       upper;
		logic                       lower;
		logic                       vig;

		// a new name clears the key and dot state before its first byte
		kp = start_s1 ? '0 : key_pos_q;
		pd = start_s1 ? 1'b0 : past_dot_q;

		if (cfg.key_length == 4'd0) begin
			len = IW'(1);
		end else if (IW'(cfg.key_length) > IW'(MAX_KEY_LEN)) begin
			len = IW'(MAX_KEY_LEN);
		end else begin
			len = IW'(cfg.key_length);
		end

		pos = (IW'(kp) < len) ? IW'(kp) : '0;
		nxt = pos + IW'(1);
		if (nxt >= len) begin
			nxt = '0;
		end

		shift = '0;
		for (int p = 0; p < clc_pkg::KEY_LETTERS; p++) begin
			if (pos == IW'(p)) begin
				shift = cfg.key_shifts[p*SW +: SW];
			end
		end
		if (shift >= clc_pkg::ALPHA) begin
			shift = shift - clc_pkg::ALPHA;
		end

		upper = (char_s1 >= clc_pkg::CH_UPPER_A) && (char_s1 <= clc_pkg::CH_UPPER_Z);
		lower = (char_s1 >= clc_pkg::CH_LOWER_A) && (char_s1 <= clc_pkg::CH_LOWER_Z);
		base  = upper ? clc_pkg::CH_UPPER_A : clc_pkg::CH_LOWER_A;
		diff  = char_s1 - base;
		x     = diff[SW-1:0];
		vig   = (cfg.cipher_mode == clc_pkg::MODE_VIG_ENC) ||
			(cfg.cipher_mode == clc_pkg::MODE_VIG_DEC);

		unique case (cfg.cipher_mode)
			clc_pkg::MODE_ATBASH: begin
				x = clc_pkg::mirror(x);
			end
			clc_pkg::MODE_ROT13: begin
				x = clc_pkg::add_mod(x, clc_pkg::ROT_AMOUNT);
				if (cfg.add_atbash) x = clc_pkg::mirror(x);
			end
			clc_pkg::MODE_VIG_ENC: begin
				if (cfg.add_atbash) x = clc_pkg::mirror(x);
				x = clc_pkg::add_mod(x, shift);
			end
			clc_pkg::MODE_VIG_DEC: begin
				// subtract modulo 26 by adding the complement shift
				x = clc_pkg::add_mod(x, (shift == '0) ? '0 : (clc_pkg::ALPHA - shift));
				if (cfg.add_atbash) x = clc_pkg::mirror(x);
			end
			default: ;
		endcase

		char_res   = char_s1;
		key_pos_d  = kp;
		past_dot_d = pd;
		if (!pd) begin
			if (char_s1 == clc_pkg::CH_DOT) begin
				past_dot_d = 1'b1;
			end else if (char_s1 == clc_pkg::CH_SLASH) begin
				key_pos_d = '0;
			end else if (upper || lower) begin
				char_res = base + {3'b000, x};
				if (vig) key_pos_d = KP_W'(nxt);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_pos_q  <= '0;
			past_dot_q <= 1'b0;
		end else if (advance) begin
			key_pos_q  <= key_pos_d;
			past_dot_q <= past_dot_d;
		end
	end

endmodule

// ===== hdl/classical_letter_cipher_stream_unit.sv =====
// ----------------------------------------------------------------------------
// classical_letter_cipher_stream_unit - streaming file-name letter cipher
// Each character passes the input register, then the result register.
// Throughput: one character per cycle unless the output stalls; the key
// position counter is updated once per character as it leaves the input
// register. Reset (arst_n, async, active low) empties both registers, clears
// the key position and dot flag, and loads the configuration defaults.
// ----------------------------------------------------------------------------
module classical_letter_cipher_stream_unit #(
	parameter int MAX_KEY_LEN = clc_pkg::DEF_MAX_KEY_LEN
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [clc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] char_in
	input  logic                           s_tuser,   // [0] name_start
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata    // [7:0] char_out
);

	clc_pkg::cfg_t cfg;

	logic                       valid_s1;
	logic [clc_pkg::CHAR_W-1:0] char_s1;
	logic                       start_s1;
	logic                       valid_s2;
	logic [clc_pkg::CHAR_W-1:0] char_s2;
	logic [clc_pkg::CHAR_W-1:0] char_res;
	logic                       s2_free;
	logic                       advance;

	assign s2_free  = !valid_s2 || m_tready;
	assign advance  = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;

	clc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	clc_xform #(
		.MAX_KEY_LEN (MAX_KEY_LEN)
	) u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.char_s1  (char_s1),
		.start_s1 (start_s1),
		.advance  (advance),
		.char_res (char_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			char_s2 <= char_res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = char_s2;

endmodule
